FILE: rtl/fbb_pkg.sv
// shared types, constants and helpers of the burst frame builder
`default_nettype none
package fbb_pkg;

  localparam int MAX_PREAMBLE = 32;
  localparam int TAIL_LENGTH  = 6;
  localparam logic [31:0] SYNC_FILL = 32'h5555_5555;

  // sequencer counter covers the preamble run and the tail run
  localparam int CNT_MAX = (MAX_PREAMBLE > TAIL_LENGTH) ? MAX_PREAMBLE : TAIL_LENGTH;
  localparam int CNT_W   = $clog2(CNT_MAX + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_BYTE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PREAMBLE_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_LENGTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WIDTH     = 3'd4;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
    logic        first_of_frame;
    logic        last_of_frame;
    logic        no_frame_waiting;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       burst_start;
    logic       burst_end;
    logic       last_result;
  } out_item_t;

  // classified work for the back end
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [15:0] frame_length;
    logic        preamble;
    logic        header;
    logic        tail;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  preamble_byte;
    logic [5:0]  preamble_count;
    logic        fixed_length_mode;
    logic [31:0] sync_pattern;
    logic [5:0]  sync_width;
  } cfg_t;

  typedef enum logic [2:0] {
    PH_NEW,
    PH_PRE,
    PH_SYNC,
    PH_LEN,
    PH_PAY,
    PH_TAIL
  } phase_t;

  function automatic logic [31:0] sync_word(input logic [31:0] pattern,
                                            input logic [5:0] width);
    logic [31:0] mask;
    if (width >= 6'd32) begin
      mask = 32'hFFFF_FFFF;
    end else begin
      mask = (32'h1 << width) - 32'h1;
    end
    return (SYNC_FILL & ~mask) | (pattern & mask);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/fbb_front.sv
// front end: accepts input bytes, tracks the burst and classifies each byte
`default_nettype none
module fbb_front import fbb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          push,
  output cmd_t          cmd
);

  logic in_burst;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.payload_byte = in_item.payload_byte;
    cmd.frame_length = in_item.frame_length;
    cmd.preamble     = !in_burst;
    cmd.header       = in_item.first_of_frame || !in_burst;
    cmd.tail         = in_item.last_of_frame && in_item.no_frame_waiting;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_burst <= 1'b0;
    end else if (push) begin
      in_burst <= !cmd.tail;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fbb_queue.sv
// short command queue between front and back end
`default_nettype none
module fbb_queue import fbb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      not_empty,
  output logic      full
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == QCNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/fbb_back.sv
// back end: byte sequencer that expands each command into the output stream
`default_nettype none
module fbb_back import fbb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire cmd_t head,
  input  wire logic q_valid,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_item_t out_item
);

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  phase_t           cur_phase;
  logic [CNT_W-1:0] cur_cnt;
  logic [CNT_W-1:0] pre_len;
  logic [31:0]      sw;
  logic             advance;
  logic             done;
  logic             is_first;
  out_item_t        item;

  assign advance = q_valid && (!out_valid || !out_stall);
  assign pop     = advance && done;
  assign sw      = sync_word(cfg.sync_pattern, cfg.sync_width);

  always_comb begin
    if (cfg.preamble_count > 6'(MAX_PREAMBLE)) begin
      pre_len = CNT_W'(MAX_PREAMBLE);
    end else begin
      pre_len = CNT_W'(cfg.preamble_count);
    end
  end

  // entry point of a fresh command
  always_comb begin
    is_first = (phase == PH_NEW);
    cur_cnt  = cnt;
    if (is_first) begin
      cur_cnt = '0;
      if (head.preamble && pre_len != '0) begin
        cur_phase = PH_PRE;
      end else if (head.header) begin
        cur_phase = PH_SYNC;
      end else begin
        cur_phase = PH_PAY;
      end
    end else begin
      cur_phase = phase;
    end
  end

  always_comb begin
    phase_next = cur_phase;
    cnt_next   = cur_cnt + CNT_W'(1);
    done       = 1'b0;
    item.out_byte    = cfg.preamble_byte;
    item.burst_start = is_first && head.preamble;
    item.burst_end   = 1'b0;
    item.last_result = 1'b0;
    unique case (cur_phase)
      PH_PRE: begin
        if (cur_cnt + CNT_W'(1) == pre_len) begin
          phase_next = PH_SYNC;
          cnt_next   = '0;
        end
      end
      PH_SYNC: begin
        unique case (cur_cnt[1:0])
          2'd0: item.out_byte = sw[31:24];
          2'd1: item.out_byte = sw[23:16];
          2'd2: item.out_byte = sw[15:8];
          2'd3: item.out_byte = sw[7:0];
        endcase
        if (cur_cnt[1:0] == 2'd3) begin
          phase_next = cfg.fixed_length_mode ? PH_PAY : PH_LEN;
          cnt_next   = '0;
        end
      end
      PH_LEN: begin
        item.out_byte = cur_cnt[0] ? head.frame_length[15:8] : head.frame_length[7:0];
        if (cur_cnt[0]) begin
          phase_next = PH_PAY;
          cnt_next   = '0;
        end
      end
      PH_PAY: begin
        item.out_byte = head.payload_byte;
        cnt_next      = '0;
        if (head.tail && TAIL_LENGTH != 0) begin
          phase_next = PH_TAIL;
        end else begin
          done = 1'b1;
        end
      end
      PH_TAIL: begin
        if (cur_cnt == CNT_W'(TAIL_LENGTH - 1)) begin
          done = 1'b1;
        end
      end
      default: begin
        item.out_byte = head.payload_byte;
        done          = 1'b1;
      end
    endcase
    if (done) begin
      phase_next       = PH_NEW;
      cnt_next         = '0;
      item.burst_end   = head.tail;
      item.last_result = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_NEW;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        phase <= phase_next;
        cnt   <= cnt_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/burst_frame_builder_top.sv
// top level of the burst frame builder: config registers, front, queue, back
//
// input channel: in_valid / in_stall with one payload byte and frame markers
// per transaction. output channel: out_valid / out_stall, one stream byte per
// transaction. config channel: cfg_valid / cfg_ready with cfg_index and
// cfg_data, always ready, to be written only while the block is idle, which
// the block itself does not enforce. each input byte yields 1 to 45 output
// bytes: preamble if it opens a burst, sync and length if it opens a frame,
// its payload byte, and tail if it closes the burst. the back-end sequencer
// emits one byte per cycle unless the queue is empty or out_stall holds it.
// a four-entry command queue lets the front keep accepting while the sequencer
// works off header and tail bytes. an accepted byte is registered in the
// queue and then in the output register. when out_stall is high the output
// register holds its byte and the sequencer waits; input accepts continue
// until the queue fills. synchronous reset empties the queue, clears the
// out_valid, leaves the block between bursts and loads default register values.
`default_nettype none
module burst_frame_builder_top import fbb_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic push, pop, q_valid, q_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.preamble_byte     <= 8'h55;
      cfg.preamble_count    <= 6'd8;
      cfg.fixed_length_mode <= 1'b0;
      cfg.sync_pattern      <= 32'h0;
      cfg.sync_width        <= 6'd32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PREAMBLE_BYTE:  cfg.preamble_byte     <= cfg_data[7:0];
        REG_PREAMBLE_COUNT: cfg.preamble_count    <= cfg_data[5:0];
        REG_FIXED_LENGTH:   cfg.fixed_length_mode <= cfg_data[0];
        REG_SYNC_PATTERN:   cfg.sync_pattern      <= cfg_data;
        REG_SYNC_WIDTH:     cfg.sync_width        <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  fbb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  fbb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .head      (head),
    .not_empty (q_valid),
    .full      (q_full)
  );

  fbb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .q_valid   (q_valid),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for the burst frame builder: random frames, stalls and register settings
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fbb_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 54;
  localparam int NUM_SETTINGS   = 8;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_item = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PREAMBLE_BYTE;
  logic [31:0]          cfg_data = '0;

  burst_frame_builder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow registers and burst state of the predictor
  logic [7:0]  pre_byte;
  logic [5:0]  pre_count;
  logic        fixed_len;
  logic [31:0] sync_pat;
  logic [5:0]  sync_w;
  logic        burst_open;

  in_item_t  payload_q[$];
  out_item_t stream_q[$];

  logic in_took = 1'b0;
  int   in_wait = 0;
  int   in_run = 0;
  int   out_hold = 0;
  int   out_run = 0;
  int   idle_cycles = 0;
  int   errors = 0;
  int   n_items = 0;
  int   n_bytes = 0;
  int   n_bursts = 0;
  int   n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, a few long ones, and now and then a long run with none
  function automatic int next_gap(inout int run);
    int r;
    if (run > 0) begin
      run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      run = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_byte(input logic [7:0] b, input logic start_flag);
    out_item_t t;
    t = '0;
    t.out_byte = b;
    t.burst_start = start_flag;
    stream_q.push_back(t);
  endfunction

  // expected stream bytes for one accepted input transaction
  function automatic void predict_stream(input in_item_t it);
    logic        start_flag;
    logic [31:0] mask;
    logic [31:0] sw;
    int          cnt;
    out_item_t   t;
    start_flag = 1'b0;
    if (it.first_of_frame || !burst_open) begin
      if (!burst_open) begin
        start_flag = 1'b1;
        cnt = (pre_count > MAX_PREAMBLE) ? MAX_PREAMBLE : int'(pre_count);
        repeat (cnt) begin
          add_byte(pre_byte, start_flag);
          start_flag = 1'b0;
        end
        burst_open = 1'b1;
      end
      if (sync_w >= 6'd32) begin
        mask = 32'hFFFF_FFFF;
      end else begin
        mask = (32'h1 << sync_w) - 32'h1;
      end
      sw = (SYNC_FILL & ~mask) | (sync_pat & mask);
      add_byte(sw[31:24], start_flag);
      add_byte(sw[23:16], 1'b0);
      add_byte(sw[15:8], 1'b0);
      add_byte(sw[7:0], 1'b0);
      if (!fixed_len) begin
        add_byte(it.frame_length[7:0], 1'b0);
        add_byte(it.frame_length[15:8], 1'b0);
      end
    end
    add_byte(it.payload_byte, 1'b0);
    t = stream_q[stream_q.size()-1];
    if (it.last_of_frame && it.no_frame_waiting) begin
      repeat (TAIL_LENGTH) add_byte(pre_byte, 1'b0);
      t = stream_q[stream_q.size()-1];
      t.burst_end = 1'b1;
      burst_open = 1'b0;
      n_bursts++;
    end
    t.last_result = 1'b1;
    stream_q[stream_q.size()-1] = t;
  endfunction

  task automatic report_diff(input string what, input int unsigned want,
                             input int unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // monitor and predictor, sampled at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      pre_byte   = 8'h55;
      pre_count  = 6'd8;
      fixed_len  = 1'b0;
      sync_pat   = 32'h0;
      sync_w     = 6'd32;
      burst_open = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PREAMBLE_BYTE:  pre_byte = cfg_data[7:0];
          REG_PREAMBLE_COUNT: pre_count = cfg_data[5:0];
          REG_FIXED_LENGTH:   fixed_len = cfg_data[0];
          REG_SYNC_PATTERN:   sync_pat = cfg_data;
          REG_SYNC_WIDTH:     sync_w = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_stream(in_item);
        in_took = 1'b1;
        n_items++;
      end
      if (out_valid && !out_stall) begin
        if (stream_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, actual out_byte %0h",
                   $time, out_item.out_byte);
        end else begin
          want = stream_q.pop_front();
          n_bytes++;
          if (out_item.out_byte !== want.out_byte)
            report_diff("out_byte", want.out_byte, out_item.out_byte);
          if (out_item.burst_start !== want.burst_start)
            report_diff("burst_start", want.burst_start, out_item.burst_start);
          if (out_item.burst_end !== want.burst_end)
            report_diff("burst_end", want.burst_end, out_item.burst_end);
          if (out_item.last_result !== want.last_result)
            report_diff("last_result", want.last_result, out_item.last_result);
        end
      end
    end
  end

  // input driver: holds a stalled transaction, otherwise gap or next item
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_took = 1'b0;
    end else if (!in_valid || in_took) begin
      in_took = 1'b0;
      if (in_wait > 0) begin
        in_valid <= 1'b0;
        in_wait--;
      end else if (payload_q.size() != 0) begin
        in_item  <= payload_q.pop_front();
        in_valid <= 1'b1;
        in_wait = next_gap(in_run);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (out_hold > 0) begin
      out_stall <= 1'b1;
      out_hold--;
    end else begin
      out_stall <= 1'b0;
      out_hold = next_gap(out_run);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void queue_item(input logic [7:0] b, input logic [15:0] len,
                                     input logic first, input logic last,
                                     input logic none_waiting);
    in_item_t it;
    it.payload_byte     = b;
    it.frame_length     = len;
    it.first_of_frame   = first;
    it.last_of_frame    = last;
    it.no_frame_waiting = none_waiting;
    payload_q.push_back(it);
  endfunction

  // one frame with random content, sometimes with broken markers
  function automatic int add_frame();
    int          len;
    int          flaw;
    int          mid;
    logic [15:0] flen;
    logic        close_burst;
    logic        first;
    logic        last;
    len  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    flen = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535)) : 16'(len);
    close_burst = ($urandom_range(0, 2) == 0);
    flaw = $urandom_range(0, 19);
    mid  = $urandom_range(0, len - 1);
    for (int i = 0; i < len; i++) begin
      first = (i == 0) && (flaw != 0);
      last  = (i == len - 1) && (flaw != 1);
      if (flaw == 2 && i == mid) first = 1'b1;
      queue_item(8'($urandom_range(0, 255)),
                 (i == 0) ? flen : 16'($urandom_range(0, 65535)),
                 first, last, last ? close_burst : 1'($urandom_range(0, 1)));
    end
    return len;
  endfunction

  task automatic wait_drained();
    while (payload_q.size() != 0 || in_valid || stream_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] b, input logic [5:0] cnt, input logic fixed,
                            input logic [31:0] pat, input logic [5:0] width);
    write_reg(REG_PREAMBLE_BYTE, {24'h0, b});
    write_reg(REG_PREAMBLE_COUNT, {26'h0, cnt});
    write_reg(REG_FIXED_LENGTH, {31'h0, fixed});
    write_reg(REG_SYNC_PATTERN, pat);
    write_reg(REG_SYNC_WIDTH, {26'h0, width});
    @(negedge clk);
    cfg_valid = 1'b0;
    n_settings++;
  endtask

  initial begin
    int queued;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    // directed frames under the reset settings
    queue_item(8'h00, 16'h0000, 1'b1, 1'b1, 1'b1);
    queue_item(8'hFF, 16'hFFFF, 1'b1, 1'b0, 1'b1);
    queue_item(8'h3C, 16'h1234, 1'b0, 1'b0, 1'b1);
    queue_item(8'hC3, 16'hABCD, 1'b1, 1'b0, 1'b0);
    queue_item(8'h5A, 16'h0000, 1'b0, 1'b1, 1'b0);
    queue_item(8'hA5, 16'h0002, 1'b1, 1'b0, 1'b0);
    queue_item(8'h01, 16'h0000, 1'b0, 1'b0, 1'b0);
    queue_item(8'h80, 16'h0000, 1'b0, 1'b1, 1'b1);
    queue_item(8'h7E, 16'h5555, 1'b0, 1'b0, 1'b0);
    queue_item(8'hE7, 16'hAAAA, 1'b0, 1'b1, 1'b1);
    queue_item(8'h11, 16'h8000, 1'b1, 1'b1, 1'b0);
    queue_item(8'h22, 16'h00FF, 1'b1, 1'b1, 1'b1);

    for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
      // sender holds off until the stream is fully drained
      wait_drained();
      case (ph)
        0: set_config(8'h00, 6'd0, 1'b1, 32'hFFFF_FFFF, 6'd0);
        1: set_config(8'hFF, 6'd63, 1'b0, 32'h1234_5678, 6'd63);
        2: set_config(8'hA5, 6'd32, 1'b1, 32'h0000_0000, 6'd32);
        3: set_config(8'h3C, 6'd1, 1'b0, $urandom, 6'd1);
        default: set_config(8'($urandom_range(0, 255)), 6'($urandom_range(0, 12)),
                            1'($urandom_range(0, 1)), $urandom,
                            6'($urandom_range(0, 63)));
      endcase
      queued = 0;
      while (queued < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 8) begin
          queued += add_frame();
        end else begin
          queue_item(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
          queued++;
        end
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (stream_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected bytes never came", $time, stream_q.size());
    end
    $display("covered %0d input transactions over %0d register settings plus reset values",
             n_items, n_settings);
    $display("compared %0d stream bytes, %0d bursts closed, %0d errors",
             n_bytes, n_bursts, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
